### sv/ffta_pkg.sv
`default_nettype none

package ffta_pkg;

   localparam int DEV_W  = 3;
   localparam int CLS_W  = 3;
   localparam int TIME_W = 63;
   localparam int ID_W   = 10;
   localparam int IDX_W  = 4;

   // track id spacing between resource classes
   localparam int CLASS_STRIDE = 100;

   typedef struct packed {
      logic load_req;
      logic cnt_rd;
      logic load_cnt;
      logic scan;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic key_ok;
      logic scan_done;
      logic rsp_free;
   } dp_sts_type;

endpackage

`default_nettype wire

### sv/ffta_ram.sv
`default_nettype none

module ffta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/ffta_ctrl.sv
`default_nettype none

module ffta_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ffta_pkg::dp_sts_type sts,
   output ffta_pkg::dp_cmd_type      cmd
);

   import ffta_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CNT    = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CNT;
            end
         end
         S_CNT: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_cnt = 1'b1;
            // a key outside the table skips the scan and answers full
            state_in     = sts.key_ok ? S_SCAN : S_COMMIT;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

### sv/ffta_datapath.sv
`default_nettype none

module ffta_datapath #(
   parameter int DEVICES = 8,
   parameter int CLASSES = 8,
   parameter int LANES   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffta_pkg::dp_cmd_type          cmd,
   output ffta_pkg::dp_sts_type               sts,
   input  wire logic [ffta_pkg::DEV_W-1:0]    req_device_index,
   input  wire logic [ffta_pkg::CLS_W-1:0]    req_resource_class,
   input  wire logic [ffta_pkg::TIME_W-1:0]   req_start_time,
   input  wire logic [ffta_pkg::TIME_W-1:0]   req_end_time,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic      [ffta_pkg::ID_W-1:0]     rsp_track_id,
   output logic      [ffta_pkg::IDX_W-1:0]    rsp_track_index,
   output logic                               rsp_tracks_full
);

   import ffta_pkg::*;

   // only devices reachable through the index field get table space
   localparam int DEV_SPAN = 1 << DEV_W;
   localparam int DEV_USED = (DEVICES < DEV_SPAN) ? DEVICES : DEV_SPAN;
   localparam int KEYS     = DEV_USED * CLASSES;
   localparam int KW       = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int CW       = $clog2(LANES + 1);
   localparam int LIW      = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int DEPTH    = KEYS * LANES;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KWIDE    = DEV_W + CLS_W + 1;

   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] end_ff, end_in;
   logic [KW-1:0]     key_ff, key_in;
   logic              key_ok_ff, key_ok_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_lane_ff, rd_lane_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     plane_ff, plane_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     lane_ff, lane_in;
   logic [KEYS-1:0]   cnt_vld_ff, cnt_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_full_ff, rsp_full_in;

   logic [KWIDE-1:0]  key_wide;
   logic [CW-1:0]     cnt_q;
   logic [TIME_W-1:0] trk_q;
   logic [AW-1:0]     trk_rd_addr;
   logic [AW-1:0]     trk_wr_addr;
   logic              hit_now;
   logic              exhausted;
   logic              issue;
   logic              full;
   logic              open_en;
   logic              trk_wr;

   assign key_wide = KWIDE'(req_device_index) * KWIDE'(CLASSES)
                   + KWIDE'(req_resource_class);

   assign trk_rd_addr = AW'(key_ff) * AW'(LANES) + AW'(rd_lane_ff[LIW-1:0]);
   assign trk_wr_addr = AW'(key_ff) * AW'(LANES) + AW'(lane_ff[LIW-1:0]);

   // read of lane i goes out one cycle, its compare happens the next
   assign hit_now   = pend_ff && (trk_q <= start_ff);
   assign exhausted = !pend_ff && (rd_lane_ff == count_ff);
   assign issue     = cmd.scan && !hit_now && (rd_lane_ff < count_ff);

   assign full    = !key_ok_ff || (!found_ff && (count_ff >= CW'(LANES)));
   assign open_en = cmd.commit && !found_ff && !full;
   assign trk_wr  = cmd.commit && !full;

   assign sts.key_ok    = key_ok_ff;
   assign sts.scan_done = hit_now || exhausted;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   ffta_ram #(
      .WIDTH (CW),
      .DEPTH (KEYS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (open_en),
      .wr_addr (key_ff),
      .wr_data (count_ff + CW'(1)),
      .rd_en   (cmd.cnt_rd),
      .rd_addr (key_ff),
      .rd_data (cnt_q)
   );

   ffta_ram #(
      .WIDTH (TIME_W),
      .DEPTH (DEPTH)
   ) u_trk_ram (
      .clock   (clock),
      .wr_en   (trk_wr),
      .wr_addr (trk_wr_addr),
      .wr_data (end_ff),
      .rd_en   (issue),
      .rd_addr (trk_rd_addr),
      .rd_data (trk_q)
   );

   always_comb begin
      cls_in       = cls_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      key_in       = key_ff;
      key_ok_in    = key_ok_ff;
      count_in     = count_ff;
      rd_lane_in   = rd_lane_ff;
      pend_in      = pend_ff;
      plane_in     = plane_ff;
      found_in     = found_ff;
      lane_in      = lane_ff;
      cnt_vld_in   = cnt_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_full_in  = rsp_full_ff;

      if (cmd.load_req) begin
         cls_in    = req_resource_class;
         start_in  = req_start_time;
         end_in    = req_end_time;
         key_in    = KW'(key_wide);
         key_ok_in = ({1'b0, req_device_index} < (DEV_W + 1)'(DEV_USED))
                  && ({1'b0, req_resource_class} < (CLS_W + 1)'(CLASSES));
      end

      if (cmd.load_cnt) begin
         // a key never opened reads as zero tracks
         count_in   = (key_ok_ff && cnt_vld_ff[key_ff]) ? cnt_q : '0;
         rd_lane_in = '0;
         pend_in    = 1'b0;
         found_in   = 1'b0;
      end

      if (cmd.scan) begin
         pend_in = issue;
         if (issue) begin
            rd_lane_in = rd_lane_ff + CW'(1);
            plane_in   = rd_lane_ff;
         end
         if (hit_now || exhausted) begin
            found_in = hit_now;
            lane_in  = hit_now ? plane_ff : count_ff;
         end
      end

      if (open_en) begin
         cnt_vld_in[key_ff] = 1'b1;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_full_in  = full;
         rsp_id_in    = full ? '0
                      : ID_W'(cls_ff) * ID_W'(CLASS_STRIDE) + ID_W'(lane_ff);
         rsp_idx_in   = full ? '0 : IDX_W'(lane_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         cnt_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         cnt_vld_ff   <= cnt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff      <= cls_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      key_ff      <= key_in;
      key_ok_ff   <= key_ok_in;
      count_ff    <= count_in;
      rd_lane_ff  <= rd_lane_in;
      plane_ff    <= plane_in;
      found_ff    <= found_in;
      lane_ff     <= lane_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_track_id    = rsp_id_ff;
   assign rsp_track_index = rsp_idx_ff;
   assign rsp_tracks_full = rsp_full_ff;

endmodule

`default_nettype wire

### sv/first_fit_track_assigner.sv
`default_nettype none

// First-fit track assigner: each transaction names a device, a resource class and a
// start/end time; the block returns the lowest track of that device/class pair whose
// last end time is not after the start, or opens the next track, and reports
// class*100 + track as the track id. One transaction is worked on at a time: after
// acceptance the open track count of the pair is read and loaded; a device or class
// outside the table skips the scan and answers full, else the scan compares the stored
// end times from the lowest lane up until one fits or the open tracks run out. The end
// times sit in one RAM with a single read port and are compared one lane per cycle.
// Loading a result also waits for as long as the previous result is stalled.
// The next transaction is accepted right after the result is loaded, even while that
// result is still stalled. Track counts are valid-bit cleared at reset; the end-time RAM
// needs no clearing pass.
module first_fit_track_assigner #(
   parameter int DEVICES = 8,
   parameter int CLASSES = 8,
   parameter int LANES   = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [ffta_pkg::DEV_W-1:0]  req_device_index,
   input  wire logic [ffta_pkg::CLS_W-1:0]  req_resource_class,
   input  wire logic [ffta_pkg::TIME_W-1:0] req_start_time,
   input  wire logic [ffta_pkg::TIME_W-1:0] req_end_time,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [ffta_pkg::ID_W-1:0]   rsp_track_id,
   output logic      [ffta_pkg::IDX_W-1:0]  rsp_track_index,
   output logic                             rsp_tracks_full
);

   import ffta_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ffta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffta_datapath #(
      .DEVICES (DEVICES),
      .CLASSES (CLASSES),
      .LANES   (LANES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_device_index   (req_device_index),
      .req_resource_class (req_resource_class),
      .req_start_time     (req_start_time),
      .req_end_time       (req_end_time),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_track_id       (rsp_track_id),
      .rsp_track_index    (rsp_track_index),
      .rsp_tracks_full    (rsp_tracks_full)
   );

endmodule

`default_nettype wire

### sv/ffta_checker.sv
`default_nettype none

module ffta_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [ffta_pkg::ID_W-1:0]   rsp_track_id,
   input wire logic [ffta_pkg::IDX_W-1:0]  rsp_track_index,
   input wire logic                        rsp_tracks_full
);

   import ffta_pkg::*;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_track_id)
         && $stable(rsp_track_index) && $stable(rsp_tracks_full))
      else $error("stalled result changed");

   // a full answer carries no track
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tracks_full |-> (rsp_track_id == '0) && (rsp_track_index == '0))
      else $error("full result with nonzero track");

   // one transaction at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a transaction while another is in work");

   // a new result only comes out of work in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a transaction in work");

endmodule

bind first_fit_track_assigner ffta_checker u_ffta_checker (.*);

`default_nettype wire

### verif/tb_first_fit_track_assigner.sv
`default_nettype none

module tb_first_fit_track_assigner;
   import ffta_pkg::*;

   localparam int DEVICES     = 8;
   localparam int CLASSES     = 8;
   localparam int LANES       = 16;
   localparam int KEYS        = DEVICES * CLASSES;
   localparam int SETTLE      = 32;
   localparam int STALL_LIMIT = 3000;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [ID_W-1:0]  track_id;
      logic [IDX_W-1:0] track_index;
      logic             tracks_full;
   } track_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic [DEV_W-1:0]  req_device_index   = '0;
   logic [CLS_W-1:0]  req_resource_class = '0;
   logic [TIME_W-1:0] req_start_time     = '0;
   logic [TIME_W-1:0] req_end_time       = '0;
   logic              rsp_valid;
   logic              rsp_stall          = 1'b0;
   logic [ID_W-1:0]   rsp_track_id;
   logic [IDX_W-1:0]  rsp_track_index;
   logic              rsp_tracks_full;

   // predictor state: last end time per track and open track count per key
   logic [TIME_W-1:0] last_end_mem [KEYS*LANES];
   int                open_tracks_mem [KEYS];
   // per-key running clock used to build well-formed activity streams
   logic [TIME_W-1:0] key_clock [KEYS];

   track_result_type track_expect_q [$];
   bit            idling_on = 1'b1;
   int            error_count = 0;
   int            results_checked = 0;
   int            overflow_count = 0;
   int            quiet_cycles = 0;

   first_fit_track_assigner #(
      .DEVICES(DEVICES),
      .CLASSES(CLASSES),
      .LANES  (LANES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_device_index   (req_device_index),
      .req_resource_class (req_resource_class),
      .req_start_time     (req_start_time),
      .req_end_time       (req_end_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_track_id       (rsp_track_id),
      .rsp_track_index    (rsp_track_index),
      .rsp_tracks_full    (rsp_tracks_full)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic track_result_type predict_track(input logic [DEV_W-1:0] dev,
                                                      input logic [CLS_W-1:0] cls,
                                                      input logic [TIME_W-1:0] start_t,
                                                      input logic [TIME_W-1:0] end_t);
      track_result_type r;
      int key;
      int count;
      int lane;
      bit found;
      r.track_id    = '0;
      r.track_index = '0;
      r.tracks_full = 1'b1;
      if (int'(dev) >= DEVICES || int'(cls) >= CLASSES) return r;
      key   = int'(dev) * CLASSES + int'(cls);
      count = open_tracks_mem[key];
      if (count > LANES) count = LANES;
      found = 1'b0;
      lane  = 0;
      for (int i = 0; i < count && !found; i++) begin
         if (last_end_mem[key*LANES + i] <= start_t) begin
            found = 1'b1;
            lane  = i;
         end
      end
      if (!found) begin
         // every open track busy and no lane left: state stays as it is
         if (count >= LANES) return r;
         lane = count;
         open_tracks_mem[key] = count + 1;
      end
      last_end_mem[key*LANES + lane] = end_t;
      r.track_id    = ID_W'(int'(cls) * CLASS_STRIDE + lane);
      r.track_index = IDX_W'(lane);
      r.tracks_full = 1'b0;
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   // leaves req_valid high after acceptance so back-to-back transactions need no toggle
   task automatic send_activity(input int dev, input int cls,
                                input logic [TIME_W-1:0] start_t,
                                input logic [TIME_W-1:0] end_t);
      track_result_type want;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_device_index   <= DEV_W'(dev);
      req_resource_class <= CLS_W'(cls);
      req_start_time     <= start_t;
      req_end_time       <= end_t;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = predict_track(DEV_W'(dev), CLS_W'(cls), start_t, end_t);
      track_expect_q = {track_expect_q, want};
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (track_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_traffic(input int n, input int key_span, input int max_step,
                              input int max_dur, input int noise_pct);
      int key_base;
      int key;
      logic [TIME_W-1:0] start_t;
      logic [TIME_W-1:0] end_t;
      key_base = $urandom_range(0, KEYS - 1);
      for (int i = 0; i < n; i++) begin
         key = (key_base + $urandom_range(0, key_span - 1)) % KEYS;
         if ($urandom_range(1, 100) <= noise_pct) begin
            case ($urandom_range(0, 2))
               0: begin
                  start_t = random_time();
                  end_t   = random_time();
               end
               1: begin
                  // end before start
                  start_t = key_clock[key] + TIME_W'($urandom_range(0, max_step));
                  end_t   = start_t - TIME_W'($urandom_range(1, 50));
               end
               default: begin
                  // latest possible start frees every track
                  start_t = TIME_MAX;
                  end_t   = key_clock[key];
               end
            endcase
         end else begin
            start_t = key_clock[key] + TIME_W'($urandom_range(0, max_step));
            end_t   = start_t + TIME_W'($urandom_range(0, max_dur));
            key_clock[key] = start_t;
         end
         send_activity(key / CLASSES, key % CLASSES, start_t, end_t);
      end
   endtask

   task automatic test_fill_and_overflow();
      for (int i = 0; i < LANES; i++) send_activity(7, 5, 100, 1000);
      send_activity(7, 5, 100, 1000);
      // end equal to start counts as free
      send_activity(7, 5, 1000, 2000);
      send_activity(7, 5, 999, 5);
      wait_for_results();
   endtask

   task automatic test_time_extremes();
      send_activity(0, 0, '0, TIME_MAX);
      send_activity(0, 0, TIME_MAX, '0);
      send_activity(0, 0, '0, '0);
      send_activity(0, 0, 50, 10);
      send_activity(0, 0, 5, 20);
      send_activity(3, 4, 7, 9);
      send_activity(5, 6, TIME_MAX, TIME_MAX);
      send_activity(2, 7, 1, 2);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      run_traffic(600, KEYS, 20, 60, 8);
      wait_for_results();
   endtask

   task automatic test_crowded_keys();
      run_traffic(200, 3, 10, 300, 5);
      run_traffic(200, 2, 5, 400, 5);
      wait_for_results();
   endtask

   task automatic test_drain_pause();
      run_traffic(50, 8, 20, 80, 10);
      // hold the sender until every outstanding transaction has answered
      wait_for_results();
      run_traffic(50, 8, 20, 80, 10);
      wait_for_results();
   endtask

   task automatic test_no_idle();
      idling_on = 1'b0;
      run_traffic(200, KEYS, 15, 80, 10);
      run_traffic(150, 4, 8, 250, 5);
      wait_for_results();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && !reset && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      track_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (track_expect_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual id %0d index %0d full %0b",
                     $time, rsp_track_id, rsp_track_index, rsp_tracks_full);
            error_count++;
         end else begin
            want = track_expect_q.pop_front();
            results_checked++;
            if (want.tracks_full) overflow_count++;
            if (rsp_track_id !== want.track_id) begin
               $display("%0t track_id mismatch: expected %0d actual %0d",
                        $time, want.track_id, rsp_track_id);
               error_count++;
            end
            if (rsp_track_index !== want.track_index) begin
               $display("%0t track_index mismatch: expected %0d actual %0d",
                        $time, want.track_index, rsp_track_index);
               error_count++;
            end
            if (rsp_tracks_full !== want.tracks_full) begin
               $display("%0t tracks_full mismatch: expected %0b actual %0b",
                        $time, want.tracks_full, rsp_tracks_full);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t timeout: no transaction for %0d cycles", $time, quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int opened;
      for (int k = 0; k < KEYS; k++) begin
         open_tracks_mem[k] = 0;
         key_clock[k]       = '0;
      end
      for (int k = 0; k < KEYS*LANES; k++) last_end_mem[k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_overflow();
      test_time_extremes();
      test_random_traffic();
      test_crowded_keys();
      test_drain_pause();
      test_no_idle();

      if (track_expect_q.size() != 0) begin
         $display("%0t %0d results never arrived", $time, track_expect_q.size());
         error_count++;
      end
      opened = 0;
      for (int k = 0; k < KEYS; k++) opened += open_tracks_mem[k];
      $display("checked %0d activities over %0d device/class keys, %0d tracks opened",
               results_checked, KEYS, opened);
      $display("%0d activities found every track busy", overflow_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
